/* src/atbs_pkg.sv */
package atbs_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WHOLE_BITS = 29;
   localparam int BKT_W      = WHOLE_BITS + FRAC_BITS;

   localparam int RATE_W  = 32;
   localparam int BITS_W  = 20;
   localparam int E_W     = 17;
   localparam int PROD_W  = 49;
   localparam int Q1_W    = 29;
   localparam int REM_W   = 20;
   localparam int CQ_W    = 30;
   localparam int KIND_W  = 3;
   localparam int CSR_W   = 2;

   localparam logic [E_W-1:0]   CAP_US    = E_W'(100000);
   localparam logic [REM_W-1:0] US_PER_S  = REM_W'(1000000);

   localparam logic [RATE_W-1:0] START_RATE_RST = RATE_W'(64000);
   localparam logic [RATE_W-1:0] MIN_RATE_RST   = RATE_W'(32000);
   localparam logic [RATE_W-1:0] MAX_RATE_RST   = RATE_W'(128000);

   // floor(x/5) = (x * DIV5_M) >> DIV5_K for x below 2^33
   localparam int DIV5_K  = 35;
   localparam int DIV5_MW = 33;
   localparam int P5_W    = RATE_W + DIV5_MW;
   localparam logic [DIV5_MW-1:0] DIV5_M = DIV5_MW'(((64'd1 << DIV5_K) + 64'd4) / 64'd5);

   // floor(x/15625) = (x * DIV_M) >> DIV_K for x below 2^48
   localparam int DIV_X_W  = 48;
   localparam int DIV_K    = 62;
   localparam int DIV_M_W  = 49;
   localparam int DIV_Q_W  = 35;
   localparam int DIV_XL_W = 24;
   localparam int DIV_ML_W = 25;
   localparam int DIV_S_W  = DIV_X_W + DIV_M_W;
   localparam logic [DIV_M_W-1:0] DIV_M =
      DIV_M_W'(((64'd1 << DIV_K) + 64'd15624) / 64'd15625);

   localparam int FRAC_SHIFT = FRAC_BITS - 6;

   localparam logic [FRAC_BITS-2:0] CAP_F1 = (FRAC_BITS-1)'((64'd1 << (FRAC_BITS-1)) / 64'd5);
   localparam logic [FRAC_BITS-2:0] CAP_F2 = (FRAC_BITS-1)'((64'd2 << (FRAC_BITS-1)) / 64'd5);
   localparam logic [FRAC_BITS-2:0] CAP_F3 = (FRAC_BITS-1)'((64'd3 << (FRAC_BITS-1)) / 64'd5);
   localparam logic [FRAC_BITS-2:0] CAP_F4 = (FRAC_BITS-1)'((64'd4 << (FRAC_BITS-1)) / 64'd5);

   localparam int NSTAGE = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_PACKET   = 3'd0,
      KIND_NONE     = 3'd1,
      KIND_BUILD    = 3'd2,
      KIND_IMMINENT = 3'd3,
      KIND_RECOVER  = 3'd4,
      KIND_LOAD     = 3'd5
   } kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_START_RATE = 2'd0,
      CSR_MIN_RATE   = 2'd1,
      CSR_MAX_RATE   = 2'd2
   } csr_type;

   typedef struct packed {
      logic a;
      logic b;
   } div_en_type;

   typedef struct packed {
      logic                upd;
      kind_type            kind;
      logic [BITS_W-1:0]   bits;
      logic [BKT_W-1:0]    gen;
      logic [BKT_W-1:0]    cap;
   } bkt_req_type;

   typedef struct packed {
      kind_type            kind;
      logic [BITS_W-1:0]   bits;
      logic [E_W-1:0]      e;
      logic [RATE_W-1:0]   rate;
      logic [RATE_W-1:0]   rnew;
      logic [PROD_W-1:0]   prod;
      logic [P5_W-1:0]     p5;
      logic [BKT_W-1:0]    cap;
      logic [Q1_W-1:0]     q1;
      logic [PROD_W-1:0]   qd;
      logic [REM_W-1:0]    rem;
   } pipe_type;

   // floor(s * 2^(FRAC_BITS-1) / 5) for a remainder s of a division by 5
   function automatic logic [FRAC_BITS-2:0] cap_frac(input logic [2:0] s);
      logic [FRAC_BITS-2:0] r;
      case (s)
         3'd1:    r = CAP_F1;
         3'd2:    r = CAP_F2;
         3'd3:    r = CAP_F3;
         3'd4:    r = CAP_F4;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* src/atbs_div15625.sv */
module atbs_div15625 (
   input  logic                           clock,
   input  atbs_pkg::div_en_type           en,
   input  logic [atbs_pkg::DIV_X_W-1:0]   x,
   output logic [atbs_pkg::DIV_Q_W-1:0]   q
);
   import atbs_pkg::*;

   localparam int XH_W = DIV_X_W - DIV_XL_W;
   localparam int MH_W = DIV_M_W - DIV_ML_W;
   localparam int LL_W = DIV_XL_W + DIV_ML_W;
   localparam int LH_W = DIV_XL_W + MH_W;
   localparam int HL_W = XH_W + DIV_ML_W;
   localparam int HH_W = XH_W + MH_W;

   logic [DIV_XL_W-1:0] xl;
   logic [XH_W-1:0]     xh;
   logic [DIV_ML_W-1:0] ml;
   logic [MH_W-1:0]     mh;

   logic [LL_W-1:0] pp_ll_ff, pp_ll_in;
   logic [LH_W-1:0] pp_lh_ff, pp_lh_in;
   logic [HL_W-1:0] pp_hl_ff, pp_hl_in;
   logic [HH_W-1:0] pp_hh_ff, pp_hh_in;
   logic [DIV_S_W-1:0] sum;
   logic [DIV_Q_W-1:0] q_ff, q_in;

   always_comb begin
      xl = x[DIV_XL_W-1:0];
      xh = x[DIV_X_W-1:DIV_XL_W];
      ml = DIV_M[DIV_ML_W-1:0];
      mh = DIV_M[DIV_M_W-1:DIV_ML_W];
      pp_ll_in = LL_W'(xl) * LL_W'(ml);
      pp_lh_in = LH_W'(xl) * LH_W'(mh);
      pp_hl_in = HL_W'(xh) * HL_W'(ml);
      pp_hh_in = HH_W'(xh) * HH_W'(mh);
      sum = DIV_S_W'(pp_ll_ff)
          + (DIV_S_W'(pp_lh_ff) << DIV_ML_W)
          + (DIV_S_W'(pp_hl_ff) << DIV_XL_W)
          + (DIV_S_W'(pp_hh_ff) << (DIV_XL_W + DIV_ML_W));
      q_in = sum[DIV_S_W-1:DIV_K];
   end

   always_ff @(posedge clock) begin
      if (en.a) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
      end
      if (en.b) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

/* src/atbs_bucket.sv */
module atbs_bucket (
   input  logic                         clock,
   input  logic                         reset,
   input  atbs_pkg::bkt_req_type        bkt_req,
   output logic                         send_ok,
   output logic [atbs_pkg::BKT_W-1:0]   bucket_next
);
   import atbs_pkg::*;

   logic [BKT_W-1:0] bucket_ff, bucket_in;
   logic [BKT_W:0]   fill;
   logic [BKT_W-1:0] capped;
   logic [BKT_W-1:0] need;

   always_comb begin
      fill    = {1'b0, bucket_ff} + {1'b0, bkt_req.gen};
      capped  = (fill > {1'b0, bkt_req.cap}) ? bkt_req.cap : fill[BKT_W-1:0];
      need    = BKT_W'(bkt_req.bits) << FRAC_BITS;
      send_ok   = 1'b0;
      bucket_in = bucket_ff;
      case (bkt_req.kind)
         KIND_PACKET: begin
            if (capped >= need) begin
               send_ok   = 1'b1;
               bucket_in = capped - need;
            end else begin
               bucket_in = capped;
            end
         end
         KIND_BUILD, KIND_IMMINENT, KIND_LOAD: begin
            bucket_in = '0;
         end
         default: begin
            bucket_in = bucket_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff <= '0;
      end else if (bkt_req.upd) begin
         bucket_ff <= bucket_in;
      end
   end

   assign bucket_next = bucket_in;

endmodule

/* src/adaptive_token_bucket_shaper_top.sv */
// Path: an accepted item is registered in stages 0-7 and then in the result register, which drives rsp_tvalid.
// Throughput: packet and no-op items are accepted every cycle while no rate-changing item is
// in the pipeline and the output is not stalled; an item that changes the rate (congestion,
// recovery, load) holds off the next item until it has left the last stage for the result
// register, since the refill math of the next packet needs the new rate.
// Reset: rate 64000, bucket empty, start/min/max rate 64000/32000/128000, pipeline empty.
module adaptive_token_bucket_shaper_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [55:0]                   req_tdata,  // packet_bits[19:0], elapsed_us[51:20], zero
   input  logic [2:0]                    req_tuser,  // kind[2:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,  // send_ok[0], rate_now[32:1],
                                                     // tokens_whole[61:33], zero
   input  logic                          csr_we,
   input  logic [atbs_pkg::CSR_W-1:0]    csr_index,
   input  logic [atbs_pkg::RATE_W-1:0]   csr_wdata
);
   import atbs_pkg::*;

   logic [RATE_W-1:0] start_rate_ff, min_rate_ff, max_rate_ff, rate_ff;
   logic [NSTAGE-1:0] v_ff, v_in;
   logic              rsp_valid_ff;
   logic              send_ok_ff;
   logic [RATE_W-1:0] rate_now_ff;
   logic [WHOLE_BITS-1:0] tokens_ff;

   pipe_type pipe_ff [NSTAGE];
   pipe_type pipe_in [NSTAGE];

   logic [NSTAGE:0]   en;
   logic              hazard;
   logic              accept;
   logic              out_load;

   logic [DIV_Q_W-1:0]   div1_q, div2_q;
   logic [DIV_X_W-1:0]   div1_x, div2_x;
   div_en_type           div1_en, div2_en;
   bkt_req_type          bkt_req;
   logic                 bkt_ok;
   logic [BKT_W-1:0]     bkt_next;

   logic [RATE_W:0]      x5;
   logic [CQ_W-1:0]      cq;
   logic [RATE_W:0]      s_full;
   logic [RATE_W:0]      v;
   logic [RATE_W:0]      vc;
   logic [PROD_W-1:0]    diff;

   // flow control: a stage loads when it is empty or its item moves on
   always_comb begin
      en[NSTAGE] = !rsp_valid_ff || rsp_tready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      hazard = 1'b0;
      for (int i = 0; i < NSTAGE; i++) begin
         if (v_ff[i] && pipe_ff[i].kind != KIND_PACKET && pipe_ff[i].kind != KIND_NONE
             && (pipe_ff[i].kind == KIND_BUILD || pipe_ff[i].kind == KIND_IMMINENT
                 || pipe_ff[i].kind == KIND_RECOVER || pipe_ff[i].kind == KIND_LOAD)) begin
            hazard = 1'b1;
         end
      end
      req_tready = en[0] && !hazard;
      accept     = req_tvalid && req_tready;
      out_load   = en[NSTAGE] && v_ff[NSTAGE-1];
      v_in[0] = accept;
      for (int i = 1; i < NSTAGE; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   // datapath per stage
   always_comb begin
      pipe_in[0] = '0;
      for (int i = 1; i < NSTAGE; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end

      // stage 0: capture item and current rate
      pipe_in[0].kind = kind_type'(req_tuser);
      pipe_in[0].bits = req_tdata[BITS_W-1:0];
      pipe_in[0].e    = (req_tdata[51:20] >= RATE_W'(CAP_US)) ? CAP_US
                                                              : req_tdata[20+E_W-1:20];
      pipe_in[0].rate = rate_ff;

      // stage 1: refill product and divide-by-5 product
      case (pipe_ff[0].kind)
         KIND_BUILD:   x5 = ((RATE_W+1)'(pipe_ff[0].rate) + (RATE_W+1)'(4)) >> 1;
         KIND_RECOVER: x5 = ((RATE_W+1)'(pipe_ff[0].rate) + (RATE_W+1)'(10)) >> 2;
         default:      x5 = (RATE_W+1)'(pipe_ff[0].rate);
      endcase
      pipe_in[1].prod = PROD_W'(pipe_ff[0].rate) * PROD_W'(pipe_ff[0].e);
      pipe_in[1].p5   = P5_W'(x5[RATE_W-1:0]) * P5_W'(DIV5_M);

      // stage 2: bucket cap and next rate
      cq     = pipe_ff[1].p5[DIV5_K+CQ_W-1:DIV5_K];
      s_full = (RATE_W+1)'(pipe_ff[1].rate) - ((RATE_W+1)'(cq) << 2) - (RATE_W+1)'(cq);
      pipe_in[2].cap = {cq, cap_frac(s_full[2:0])};
      case (pipe_ff[1].kind)
         KIND_BUILD:    v = (RATE_W+1)'(pipe_ff[1].rate) - (RATE_W+1)'(cq);
         KIND_IMMINENT: v = (RATE_W+1)'(pipe_ff[1].rate)
                          - (((RATE_W+1)'(pipe_ff[1].rate) + (RATE_W+1)'(1)) >> 2);
         KIND_RECOVER:  v = (RATE_W+1)'(pipe_ff[1].rate) + (RATE_W+1)'(cq);
         default:       v = (RATE_W+1)'(pipe_ff[1].rate);
      endcase
      if (v[RATE_W]) begin
         v = {1'b0, {RATE_W{1'b1}}};
      end
      vc = (v > (RATE_W+1)'(max_rate_ff)) ? (RATE_W+1)'(max_rate_ff) : v;
      vc = (vc < (RATE_W+1)'(min_rate_ff)) ? (RATE_W+1)'(min_rate_ff) : vc;
      case (pipe_ff[1].kind)
         KIND_BUILD, KIND_IMMINENT, KIND_RECOVER: pipe_in[2].rnew = vc[RATE_W-1:0];
         KIND_LOAD:                               pipe_in[2].rnew = start_rate_ff;
         default:                                 pipe_in[2].rnew = pipe_ff[1].rate;
      endcase

      // stage 4: whole tokens and their share of the product
      pipe_in[4].q1 = div1_q[Q1_W-1:0];
      pipe_in[4].qd = PROD_W'(div1_q[Q1_W-1:0]) * PROD_W'(US_PER_S);

      // stage 5: remainder of the division by 1e6
      diff = pipe_ff[4].prod - pipe_ff[4].qd;
      pipe_in[5].rem = diff[REM_W-1:0];

      div1_x = DIV_X_W'(pipe_ff[1].prod >> 6);
      div2_x = DIV_X_W'(pipe_ff[5].rem) << FRAC_SHIFT;
      div1_en.a = en[2];
      div1_en.b = en[3];
      div2_en.a = en[6];
      div2_en.b = en[7];

      bkt_req.upd  = out_load;
      bkt_req.kind = pipe_ff[NSTAGE-1].kind;
      bkt_req.bits = pipe_ff[NSTAGE-1].bits;
      bkt_req.gen  = {pipe_ff[NSTAGE-1].q1, div2_q[FRAC_BITS-1:0]};
      bkt_req.cap  = pipe_ff[NSTAGE-1].cap;
   end

   atbs_div15625 u_div_whole (
      .clock (clock),
      .en    (div1_en),
      .x     (div1_x),
      .q     (div1_q)
   );

   atbs_div15625 u_div_frac (
      .clock (clock),
      .en    (div2_en),
      .x     (div2_x),
      .q     (div2_q)
   );

   atbs_bucket u_bucket (
      .clock       (clock),
      .reset       (reset),
      .bkt_req     (bkt_req),
      .send_ok     (bkt_ok),
      .bucket_next (bkt_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_rate_ff <= START_RATE_RST;
         min_rate_ff   <= MIN_RATE_RST;
         max_rate_ff   <= MAX_RATE_RST;
         rate_ff       <= START_RATE_RST;
         v_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_type'(csr_index))
               CSR_START_RATE: start_rate_ff <= csr_wdata;
               CSR_MIN_RATE:   min_rate_ff   <= csr_wdata;
               CSR_MAX_RATE:   max_rate_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         for (int i = 0; i < NSTAGE; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
         if (en[NSTAGE]) begin
            rsp_valid_ff <= v_ff[NSTAGE-1];
         end
         if (out_load) begin
            rate_ff <= pipe_ff[NSTAGE-1].rnew;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
      if (out_load) begin
         send_ok_ff  <= bkt_ok;
         rate_now_ff <= pipe_ff[NSTAGE-1].rnew;
         tokens_ff   <= bkt_next[BKT_W-1:FRAC_BITS];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, tokens_ff, rate_now_ff, send_ok_ff};

endmodule
